FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level formatter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/dsegf_pkg.sv
// Shared types, constants and segment encoding for the decimal display formatter
package dsegf_pkg;

  localparam int unsigned VALUE_W = 17;
  localparam int unsigned SEG_W   = 8;

  localparam logic [VALUE_W-1:0] MAX_SHOWN = 17'd99999;
  localparam logic [SEG_W-1:0]   SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0]   SEG_POINT = 8'h01;

  // Segment bytes for digits zero through nine
  localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
    8'hBE, 8'h06, 8'hDC, 8'hCE, 8'h66, 8'hEA, 8'hFA, 8'h86, 8'hFE, 8'hEE
  };

  typedef struct packed {
    logic blank0;  // ten-thousands digit dark
    logic blank1;  // thousands digit dark
    logic ovf;     // input saturated
  } flags_t;

  typedef struct packed {
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [3:0] d3;
    logic [3:0] d4;
    flags_t     flags;
  } digits_t;

  // Map one decimal digit to its segment byte
  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = SEG_TABLE[0];
      4'd1:    seg = SEG_TABLE[1];
      4'd2:    seg = SEG_TABLE[2];
      4'd3:    seg = SEG_TABLE[3];
      4'd4:    seg = SEG_TABLE[4];
      4'd5:    seg = SEG_TABLE[5];
      4'd6:    seg = SEG_TABLE[6];
      4'd7:    seg = SEG_TABLE[7];
      4'd8:    seg = SEG_TABLE[8];
      4'd9:    seg = SEG_TABLE[9];
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/dsegf_digit_pipe.sv
// Six-stage pipeline that saturates the value and splits it into five decimal digits
module dsegf_digit_pipe
  import dsegf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VALUE_W-1:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output digits_t            out_digits_o
);

  // Reciprocal constants: floor(x/1000) for x < 100000, floor(x/10) for x < 100,
  // floor(x/100) for x < 1000
  localparam logic [17:0] DIV1000_MUL = 18'd134218;
  localparam int unsigned DIV1000_SH  = 27;
  localparam logic [6:0]  DIV10_MUL   = 7'd103;
  localparam int unsigned DIV10_SH    = 10;
  localparam logic [5:0]  DIV100_MUL  = 6'd41;
  localparam int unsigned DIV100_SH   = 12;
  localparam int unsigned NSTAGE      = 6;

  logic [NSTAGE:0]   vld_in;
  logic [NSTAGE:1]   vld_q, vld_d;
  logic [NSTAGE+1:1] rdy;

  // Stage payload registers
  logic [VALUE_W-1:0] v1_q, v2_q;
  flags_t             f1_q, f2_q, f3_q, f4_q, f5_q;
  logic [6:0]         hi2_q, hi3_q;
  logic [9:0]         lo3_q, lo4_q;
  logic [3:0]         d0_3_q, d0_4_q, d0_5_q;
  logic [3:0]         d1_4_q, d1_5_q;
  logic [3:0]         d2_4_q, d2_5_q;
  logic [6:0]         r5_q;
  digits_t            out6_q;

  // Next values
  logic               sat1;
  logic [VALUE_W-1:0] v1_d;
  flags_t             f1_d;
  logic [34:0]        prod2;
  logic [6:0]         hi2_d;
  logic [16:0]        prod3, diff3;
  logic [13:0]        prod3_d0;
  logic [9:0]         lo3_d;
  logic [3:0]         d0_3_d;
  logic [6:0]         diff4;
  logic [15:0]        prod4;
  logic [3:0]         d1_4_d, d2_4_d;
  logic [9:0]         diff5;
  logic [6:0]         r5_d;
  logic [13:0]        prod6;
  logic [6:0]         diff6;
  digits_t            out6_d;

  // Ready ripples back: a stage loads when empty or when its successor loads
  assign vld_in[0]     = in_valid_i;
  always_comb begin
    rdy[NSTAGE+1] = out_ready_i;
    for (int k = NSTAGE; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    for (int k = 1; k <= NSTAGE; k++) begin
      vld_d[k] = rdy[k] ? vld_in[k-1] : vld_q[k];
    end
  end
  assign vld_in[NSTAGE:1] = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: saturate and flag blanked leading digits
  always_comb begin
    sat1        = in_value_i > MAX_SHOWN;
    v1_d        = sat1 ? MAX_SHOWN : in_value_i;
    f1_d.ovf    = sat1;
    f1_d.blank0 = v1_d < 17'd10000;
    f1_d.blank1 = v1_d < 17'd1000;
  end

  // Stage 2: thousands quotient by reciprocal multiply
  always_comb begin
    prod2 = 35'(v1_q) * 35'(DIV1000_MUL);
    hi2_d = prod2[DIV1000_SH+6:DIV1000_SH];
  end

  // Stage 3: remainder below one thousand, ten-thousands digit
  always_comb begin
    prod3    = 17'(hi2_q) * 17'd1000;
    diff3    = v2_q - prod3;
    lo3_d    = diff3[9:0];
    prod3_d0 = 14'(hi2_q) * 14'(DIV10_MUL);
    d0_3_d   = prod3_d0[DIV10_SH+3:DIV10_SH];
  end

  // Stage 4: thousands digit and hundreds digit
  always_comb begin
    diff4  = hi3_q - 7'({d0_3_q, 3'b000}) - 7'({d0_3_q, 1'b0});
    d1_4_d = diff4[3:0];
    prod4  = 16'(lo3_q) * 16'(DIV100_MUL);
    d2_4_d = prod4[DIV100_SH+3:DIV100_SH];
  end

  // Stage 5: remainder below one hundred
  always_comb begin
    diff5 = lo4_q - 10'({d2_4_q, 6'b0}) - 10'({d2_4_q, 5'b0}) - 10'({d2_4_q, 2'b0});
    r5_d  = diff5[6:0];
  end

  // Stage 6: tens and units digits
  always_comb begin
    prod6        = 14'(r5_q) * 14'(DIV10_MUL);
    out6_d.d0    = d0_5_q;
    out6_d.d1    = d1_5_q;
    out6_d.d2    = d2_5_q;
    out6_d.d3    = prod6[DIV10_SH+3:DIV10_SH];
    diff6        = r5_q - 7'({out6_d.d3, 3'b000}) - 7'({out6_d.d3, 1'b0});
    out6_d.d4    = diff6[3:0];
    out6_d.flags = f5_q;
  end

  // Advance payload on each stage's load enable
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      v1_q <= v1_d;
      f1_q <= f1_d;
    end
    if (rdy[2]) begin
      v2_q  <= v1_q;
      hi2_q <= hi2_d;
      f2_q  <= f1_q;
    end
    if (rdy[3]) begin
      lo3_q  <= lo3_d;
      hi3_q  <= hi2_q;
      d0_3_q <= d0_3_d;
      f3_q   <= f2_q;
    end
    if (rdy[4]) begin
      lo4_q  <= lo3_q;
      d0_4_q <= d0_3_q;
      d1_4_q <= d1_4_d;
      d2_4_q <= d2_4_d;
      f4_q   <= f3_q;
    end
    if (rdy[5]) begin
      r5_q   <= r5_d;
      d0_5_q <= d0_4_q;
      d1_5_q <= d1_4_q;
      d2_5_q <= d2_4_q;
      f5_q   <= f4_q;
    end
    if (rdy[6]) begin
      out6_q <= out6_d;
    end
  end

  assign in_ready_o   = rdy[1];
  assign out_valid_o  = vld_q[NSTAGE];
  assign out_digits_o = out6_q;

endmodule

FILE: rtl/decimal_seven_segment_formatter.sv
// Input beats pass the digit pipeline, then the output register. Throughput:
// one beat per cycle while the sink is ready; the pipeline and the output
// register fill bubbles independently, so input can be taken while a result
// waits. Each stage holds about one constant-multiply and subtract.
// Reset: asynchronous, active low; clears all valid bits, no result pending.
module decimal_seven_segment_formatter
  import dsegf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [16:0] value, [23:17] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // seg_digit0, seg_digit1, seg_digit2,
                                        // seg_digit3, seg_digit4 (8 bits each)
  output logic        m_axis_tuser_o    // overflow
);

`include "assert_macros.svh"

  logic        pipe_valid, pipe_ready;
  digits_t     pipe_digits;
  logic        m_tvalid_q, m_tvalid_d;
  logic [39:0] m_tdata_q, m_tdata_d;
  logic        m_tuser_q;

  dsegf_digit_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_value_i   (s_axis_tdata_i[VALUE_W-1:0]),
    .out_valid_o  (pipe_valid),
    .out_ready_i  (pipe_ready),
    .out_digits_o (pipe_digits)
  );

  // Output register loads when empty or when its beat is taken
  assign pipe_ready = !m_tvalid_q || m_axis_tready_i;
  assign m_tvalid_d = pipe_ready ? pipe_valid : m_tvalid_q;

  // Encode digits into segment bytes, blank leading zeros, light the point
  always_comb begin
    m_tdata_d[7:0]   = pipe_digits.flags.blank0 ? SEG_BLANK : seg_encode(pipe_digits.d0);
    m_tdata_d[15:8]  = pipe_digits.flags.blank1 ? SEG_BLANK : seg_encode(pipe_digits.d1);
    m_tdata_d[23:16] = seg_encode(pipe_digits.d2) | SEG_POINT;
    m_tdata_d[31:24] = seg_encode(pipe_digits.d3);
    m_tdata_d[39:32] = seg_encode(pipe_digits.d4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else begin
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_ready) begin
      m_tdata_q <= m_tdata_d;
      m_tuser_q <= pipe_digits.flags.ovf;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  // Saturated beats show nine everywhere with the point on digit 2
  `ASSERT_IMPL(a_ovf_nines, clk_i, rst_ni, m_tvalid_q && m_tuser_q, m_tdata_q == 40'hEEEEEFEEEE)
  // Ten-thousands digit lit implies thousands digit lit
  `ASSERT_IMPL(a_blank_order, clk_i, rst_ni, m_tvalid_q && (m_tdata_q[7:0] != SEG_BLANK), m_tdata_q[15:8] != SEG_BLANK)
  // A beat from the pipe while the output is free lands in the output register
  `ASSERT_NEXT(a_out_load, clk_i, rst_ni, pipe_valid && pipe_ready, m_tvalid_q)

endmodule

FILE: verif/decimal_seven_segment_formatter_test.sv
// Stream testbench for the decimal seven-segment formatter with a self-checking scoreboard

// Segment glyphs for digits zero through nine, kept apart from the RTL table
localparam logic [7:0] DIGIT_GLYPH [10] = '{
  8'hBE, 8'h06, 8'hDC, 8'hCE, 8'h66, 8'hEA, 8'hFA, 8'h86, 8'hFE, 8'hEE
};
localparam logic [7:0]  GLYPH_DARK  = 8'h00;
localparam logic [7:0]  GLYPH_POINT = 8'h01;
localparam int unsigned TOP_READING = 99999;

// One output beat: five segment bytes, digit 0 in the lowest byte, plus the flag
typedef struct packed {
  logic            overflow;
  logic [4:0][7:0] seg;
} display_t;

class display_scoreboard;
  display_t expected_displays [$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Work out the five-digit reading for one accepted value
  function display_t predict_display(logic [16:0] value);
    display_t    d;
    int unsigned n;
    n = value;
    d.overflow = 1'b0;
    if (n > TOP_READING) begin
      n = TOP_READING;
      d.overflow = 1'b1;
    end
    d.seg[0] = (n < 10000) ? GLYPH_DARK : DIGIT_GLYPH[(n / 10000) % 10];
    d.seg[1] = (n < 1000)  ? GLYPH_DARK : DIGIT_GLYPH[(n / 1000) % 10];
    d.seg[2] = DIGIT_GLYPH[(n / 100) % 10] | GLYPH_POINT;
    d.seg[3] = DIGIT_GLYPH[(n / 10) % 10];
    d.seg[4] = DIGIT_GLYPH[n % 10];
    return d;
  endfunction

  function void note_value(logic [16:0] value);
    expected_displays.push_back(predict_display(value));
  endfunction

  // Compare one output beat with the oldest expected reading
  function void check_display(logic [39:0] data, logic flag, time stamp);
    display_t want;
    if (expected_displays.size() == 0) begin
      $display("%0t: unexpected output beat data=%h overflow=%b", stamp, data, flag);
      mismatches++;
      return;
    end
    want = expected_displays.pop_front();
    for (int i = 0; i < 5; i++) begin
      if (data[i*8 +: 8] !== want.seg[i]) begin
        $display("%0t: seg_digit%0d expected %h actual %h",
                 stamp, i, want.seg[i], data[i*8 +: 8]);
        mismatches++;
      end
    end
    if (flag !== want.overflow) begin
      $display("%0t: overflow expected %b actual %b", stamp, want.overflow, flag);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return expected_displays.size();
  endfunction
endclass

module decimal_seven_segment_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned CORNER_VALUES [24] = '{
    0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 12345, 67890,
    99999, 100000, 131071, 24680, 13579, 11111, 55555, 50505, 98765, 2, 86420, 100001
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  display_scoreboard sb;
  bit                long_hold_req = 1'b0;
  bit                no_idle       = 1'b0;
  int unsigned       cycle_count   = 0;

  decimal_seven_segment_formatter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hold reset low at start, then release it on a clock edge
  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stop a hung run
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[decimal_seven_segment_formatter] ERROR");
        $finish;
      end
    end
  end

  // Drive the sink ready in bursts, with one long hold-off on request
  initial begin : sink_side
    int unsigned stretch;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else if (no_idle || $urandom_range(3) != 0) begin
        m_tready <= 1'b1;
        stretch = no_idle ? 1 : $urandom_range(20, 1);
        repeat (stretch - 1) @(posedge clk_i);
      end else begin
        m_tready <= 1'b0;
        stretch = $urandom_range(7, 1);
        repeat (stretch - 1) @(posedge clk_i);
      end
    end
  end

  // Check every output beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_display(m_axis_tdata_o, m_axis_tuser_o, $time);
  end

  // Offer one value and return at the edge that accepts it
  task automatic send_value(input logic [16:0] value);
    s_tdata  <= {7'd0, value};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_value(value);
  endtask

  // Drop valid for a random gap now and then
  task automatic source_gap();
    if (!no_idle && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Mix full-range values, short readings, decade edges and saturating values
  function automatic logic [16:0] pick_value();
    int unsigned v;
    int unsigned decade;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(TOP_READING);
      4: v = $urandom_range(10 ** $urandom_range(4, 1) - 1);
      5: v = $urandom_range(131071, 100000);
      6, 7: begin
        decade = 10 ** $urandom_range(5, 1);
        v = decade - 2 + $urandom_range(4);
      end
      default: v = $urandom & 32'h1FFFF;
    endcase
    return v[16:0];
  endfunction

  initial begin : source_side
    sb = new();
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    // Directed corners: blanking edges, every digit, saturation
    foreach (CORNER_VALUES[i]) begin
      send_value(CORNER_VALUES[i][16:0]);
      source_gap();
    end

    // Random values with a long sink stall and one full drain
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 980) no_idle = 1'b1;
      send_value(pick_value());
      if (k == 300) long_hold_req = 1'b1;
      if (k == 650) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end else begin
        source_gap();
      end
    end
    s_tvalid <= 1'b0;

    // Let the pipeline empty, then settle
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("[decimal_seven_segment_formatter] OK");
    else
      $display("[decimal_seven_segment_formatter] ERROR");
    $finish;
  end
endmodule
